FILE: hw/rtl/bis_pkg.sv
package bis_pkg;

    // store geometry and element width
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ADDR_W     = $clog2(DEPTH);

    // output buffer geometry
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [ADDR_W-1:0]     t_addr;

    // one request to the element store: one write and one read port
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_data wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_mem_req;

    // one element of the sorted run
    typedef struct packed {
        t_data value;
        logic  last;
        logic  overflow;
    } t_out_item;

    typedef struct packed {
        logic      push;
        t_out_item item;
    } t_obuf_push;

    typedef struct packed {
        logic [OBUF_CW-1:0] count;
    } t_obuf_stat;

    // sign bit flipped so that an unsigned compare gives the signed order
    function automatic t_data f_key(t_data v);
        return {~v[DATA_WIDTH-1], v[DATA_WIDTH-2:0]};
    endfunction

endpackage

FILE: hw/rtl/bis_if.sv
// input channel: one element per transfer
interface bis_in_if;
    import bis_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

// output channel: one element of the sorted run per transfer
interface bis_out_if;
    import bis_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

FILE: hw/rtl/bis_mem.sv
module bis_mem (
    input  logic              i_clk,
    input  bis_pkg::t_mem_req i_req,
    output bis_pkg::t_data    o_q
);
    import bis_pkg::*;

    t_data r_mem [DEPTH];
    t_data r_q;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // single read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    assign o_q = r_q;
endmodule

FILE: hw/rtl/bis_obuf.sv
module bis_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bis_pkg::t_obuf_push i_push,
    output bis_pkg::t_obuf_stat o_stat,
    bis_out_if.source           o_out
);
    import bis_pkg::*;

    t_out_item           r_buf [OBUF_DEPTH];
    logic [OBUF_AW-1:0]  r_wptr;
    logic [OBUF_AW-1:0]  r_rptr;
    logic [OBUF_CW-1:0]  r_cnt;
    logic                w_pop;

    assign w_pop = o_out.valid && o_out.ready;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_buf[r_wptr] <= i_push.item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push.push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // head of the buffer drives the channel
    assign o_out.valid        = (r_cnt != '0);
    assign o_out.sorted_value = $signed(r_buf[r_rptr].value);
    assign o_out.last_out     = r_buf[r_rptr].last;
    assign o_out.overflow     = r_buf[r_rptr].overflow;
    assign o_stat.count       = r_cnt;
endmodule

FILE: hw/rtl/bis_seq.sv
module bis_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bis_in_if.sink              i_in,
    input  bis_pkg::t_data      i_q,
    input  bis_pkg::t_obuf_stat i_stat,
    output bis_pkg::t_mem_req   o_req,
    output bis_pkg::t_obuf_push o_push
);
    import bis_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_cnt   r_count;
    logic   r_dropped;
    t_data  r_val;
    logic   r_last;
    t_data  r_tail;
    t_cnt   r_lo;
    t_cnt   r_hi;
    t_cnt   r_mid;
    t_cnt   r_idx;
    t_addr  r_waddr;
    logic   r_wpend;
    logic   r_epend;
    logic   r_elast;

    logic              w_in_acc;
    logic              w_full;
    logic              w_append;
    logic [CNT_W:0]    w_sum;
    t_cnt              w_mid;
    t_cnt              w_idx_m1;
    logic              w_credit;
    logic [OBUF_CW:0]  w_used;
    t_mem_req          w_req;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_append   = (r_count == '0) || (f_key(t_data'(i_in.value)) >= f_key(r_tail));

    // search midpoint and shift source index
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[CNT_W:1];
    assign w_idx_m1 = r_idx - 1'b1;

    // room in the output buffer, counting the read in flight
    assign w_used   = (OBUF_CW+1)'(i_stat.count) + (OBUF_CW+1)'(r_epend);
    assign w_credit = (w_used < (OBUF_CW+1)'(OBUF_DEPTH));

    // store requests for the current step
    always_comb begin
        w_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && !w_full && w_append) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_count[ADDR_W-1:0];
                    w_req.wr_data = t_data'(i_in.value);
                end
            end
            ST_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = w_mid[ADDR_W-1:0];
                end
            end
            ST_SRCH_CMP: begin
                w_req = '0;
            end
            ST_SHIFT: begin
                if (r_wpend) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_waddr;
                    w_req.wr_data = i_q;
                end
                if (r_idx > r_lo) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = w_idx_m1[ADDR_W-1:0];
                end
            end
            ST_PLACE: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_lo[ADDR_W-1:0];
                w_req.wr_data = r_val;
            end
            ST_EMIT: begin
                if (r_idx != r_count && w_credit) begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = r_idx[ADDR_W-1:0];
                end
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    assign o_req            = w_req;
    assign o_push.push      = r_epend;
    assign o_push.item      = '{value: i_q, last: r_elast, overflow: r_dropped};

    // sequencer state and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_wpend   <= 1'b0;
            r_epend   <= 1'b0;
        end else begin
            r_epend <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_val  <= t_data'(i_in.value);
                        r_last <= i_in.last_item;
                        r_idx  <= '0;
                        if (w_full) begin
                            r_dropped <= 1'b1;
                            if (i_in.last_item) begin
                                r_state <= ST_EMIT;
                            end
                        end else if (w_append) begin
                            r_count <= r_count + 1'b1;
                            r_tail  <= t_data'(i_in.value);
                            if (i_in.last_item) begin
                                r_state <= ST_EMIT;
                            end
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= r_count;
                            r_state <= ST_SRCH_RD;
                        end
                    end
                end
                ST_SRCH_RD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= ST_SRCH_CMP;
                    end else begin
                        r_idx   <= r_count;
                        r_wpend <= 1'b0;
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SRCH_CMP: begin
                    // upper bound: equal entries stay below the new value
                    if (f_key(i_q) <= f_key(r_val)) begin
                        r_lo <= r_mid + 1'b1;
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= ST_SRCH_RD;
                end
                ST_SHIFT: begin
                    if (r_idx > r_lo) begin
                        r_waddr <= r_idx[ADDR_W-1:0];
                        r_wpend <= 1'b1;
                        r_idx   <= w_idx_m1;
                    end else begin
                        r_wpend <= 1'b0;
                        r_state <= ST_PLACE;
                    end
                end
                ST_PLACE: begin
                    r_count <= r_count + 1'b1;
                    r_idx   <= '0;
                    r_state <= r_last ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (r_idx != r_count) begin
                        if (w_credit) begin
                            r_epend <= 1'b1;
                            r_elast <= (CNT_W'(r_idx + 1'b1) == r_count);
                            r_idx   <= r_idx + 1'b1;
                        end
                    end else begin
                        // final element is pushed this cycle
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // fill count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("held count beyond store depth");

    // shift moves never read and write the same entry
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.wr_en && w_req.rd_en) |-> (w_req.wr_addr != w_req.rd_addr))
        else $error("store read and write collide");

    // search window stays inside the held entries
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH_RD) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search bounds out of range");

    // emission never overruns the output buffer
    a_obuf_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epend |-> (i_stat.count < OBUF_CW'(OBUF_DEPTH)))
        else $error("push into full output buffer");
endmodule

FILE: hw/rtl/binary_insertion_sorter_unit.sv
// Binary insertion sorter.
// i_in carries signed values with a last_item flag; a transfer happens when valid
// and ready are high at a clock edge. Each value goes into a 64-entry sorted store.
// A value not below the largest held one is appended in the transfer cycle and the
// next value can follow at once. Otherwise a binary search over the store memory
// takes a read step and a compare step per probe, the larger entries move up one
// per cycle, and a place step then writes the new value. The registered read of
// the store memory is why each probe needs both steps. ready is low while an
// insertion or an emission runs.
// After the last item the run leaves on o_out in ascending order, one element per
// cycle when the receiver keeps ready high, each read from the store and pushed
// into the output buffer first; last_out marks the final element and overflow is set
// on every element if values arrived while the store was full (those are dropped).
// A 4-entry output buffer absorbs receiver stalls; the read-out simply pauses.
// Reset empties the store at once: no clearing pass is needed.
module binary_insertion_sorter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bis_in_if.sink    i_in,
    bis_out_if.source o_out
);
    import bis_pkg::*;

    t_mem_req   w_req;
    t_data      w_q;
    t_obuf_push w_push;
    t_obuf_stat w_stat;

    // insertion and read-out sequencer
    bis_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q     (w_q),
        .i_stat  (w_stat),
        .o_req   (w_req),
        .o_push  (w_push)
    );

    // sorted element store
    bis_mem u_mem (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_q   (w_q)
    );

    // output buffer toward the receiver
    bis_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );
endmodule
